[rtl/packed_upper_triangular_matmul_assert.svh]
// Assertion macros shared by the packed triangular multiply RTL.
`ifndef PACKED_UPPER_TRIANGULAR_MATMUL_ASSERT_SVH
`define PACKED_UPPER_TRIANGULAR_MATMUL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PTUM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptum: implication check failed");

// Next-cycle implication, disabled during reset.
`define PTUM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptum: next-cycle check failed");

`endif

[rtl/ptum_pkg.sv]
// ----------------------------------------------------------------------------
// ptum_pkg
// Types and constants of the packed upper-triangular matrix multiply.
// ----------------------------------------------------------------------------
package ptum_pkg;

    localparam int CMD_W  = 2;
    localparam int ROW_W  = 6;
    localparam int VAL_W  = 32;
    localparam int SIZE_W = 7;
    localparam int ACC_W  = 72;

    localparam logic [CMD_W-1:0] CMD_LD_U = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LD_F = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMP = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [ROW_W-1:0]        row;
        logic [ROW_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [ROW_W-1:0]        out_row;
        logic [ROW_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COMP,
        ST_DRAIN
    } t_state;

    // shift control broadcast along the cell chain
    typedef struct packed {
        logic             shift;
        logic             ins_en;
        logic [ROW_W-1:0] pos;
    } t_chain_ctl;

    // per-product tag that travels with the MAC pipeline
    typedef struct packed {
        logic             first;
        logic             lastk;
        logic [ROW_W-1:0] row;
        logic             lastrow;
    } t_mac_tag;

endpackage

[rtl/ptum_cell.sv]
// ----------------------------------------------------------------------------
// ptum_cell
// One cell of the F column chain: takes its right neighbor on a shift, or
// the insert value when the insert position names this cell.
// ----------------------------------------------------------------------------
module ptum_cell #(
    parameter int IDX = 0
) (
    input  logic                                 i_clk,
    input  ptum_pkg::t_chain_ctl                 i_ctl,
    input  logic signed [ptum_pkg::VAL_W-1:0]    i_nb,
    input  logic signed [ptum_pkg::VAL_W-1:0]    i_ins,
    output logic signed [ptum_pkg::VAL_W-1:0]    o_q
);
    import ptum_pkg::*;

    logic signed [VAL_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_q <= (i_ctl.ins_en && i_ctl.pos == ROW_W'(IDX)) ? i_ins : i_nb;
        end
    end

    assign o_q = r_q;

endmodule

[rtl/ptum_mac.sv]
// ----------------------------------------------------------------------------
// ptum_mac
// Multiply, exact accumulate, round half up and saturate to Q16.16.
// ----------------------------------------------------------------------------
module ptum_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  ptum_pkg::t_mac_tag                i_tag,
    input  logic signed [ptum_pkg::VAL_W-1:0] i_a,
    input  logic signed [ptum_pkg::VAL_W-1:0] i_b,
    output logic                              o_valid,
    output logic [ptum_pkg::ROW_W-1:0]        o_row,
    output logic                              o_last,
    output logic signed [ptum_pkg::VAL_W-1:0] o_value
);
    import ptum_pkg::*;

    logic                      r_pv;
    t_mac_tag                  r_pt;
    logic signed [2*VAL_W-1:0] r_p;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_fv;
    logic [ROW_W-1:0]          r_frow;
    logic                      r_flast;
    logic                      r_ov;
    logic [ROW_W-1:0]          r_orow;
    logic                      r_olast;
    logic signed [VAL_W-1:0]   r_oval;

    logic signed [ACC_W-1:0]   p_ext;
    logic signed [ACC_W-1:0]   rnd;
    logic                      fits;
    logic signed [VAL_W-1:0]   sat;

    assign p_ext = {{(ACC_W-2*VAL_W){r_p[2*VAL_W-1]}}, r_p};
    assign rnd   = r_acc + ACC_W'(32768);
    // result fits when bits 47 and up are all sign copies
    assign fits  = (&rnd[ACC_W-1:47]) | ~(|rnd[ACC_W-1:47]);
    assign sat   = fits ? rnd[47:16] : (rnd[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_fv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_pv <= i_valid;
            r_fv <= r_pv & r_pt.lastk;
            r_ov <= r_fv;
        end
        r_p  <= i_a * i_b;
        r_pt <= i_tag;
        if (r_pv) begin
            r_acc <= r_pt.first ? p_ext : r_acc + p_ext;
        end
        r_frow  <= r_pt.row;
        r_flast <= r_pt.lastrow;
        r_orow  <= r_frow;
        r_olast <= r_flast;
        r_oval  <= sat;
    end

    assign o_valid = r_ov;
    assign o_row   = r_orow;
    assign o_last  = r_olast;
    assign o_value = r_oval;

endmodule

[rtl/packed_upper_triangular_matmul.sv]
// ----------------------------------------------------------------------------
// packed_upper_triangular_matmul
// F <- U*F one column per compute request; U packed by rows from diagonal.
//
//   channel   signals                        direction
//   request   start, busy, i_req             in
//   result    o_strobe, o_res                out
//   config    i_cfg_we, i_cfg_wdata (size_n) in
//
// Load requests write the U or F store directly. A compute request on n rows
// copies the column into the cell chain, then runs n(n+1)/2 MACs (one U
// memory read per cycle feeds the single multiplier), then drains the MAC
// pipeline; busy is high throughout.
// Results stream out, one strobe per row, and cannot be stalled.
// Reset clears control only; U and F stores hold garbage until written.
// ----------------------------------------------------------------------------
module packed_upper_triangular_matmul #(
    parameter int N_MAX  = 64,
    parameter int M_COLS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  ptum_pkg::t_req               i_req,
    input  logic                         i_cfg_we,
    input  logic [ptum_pkg::SIZE_W-1:0]  i_cfg_wdata,
    output logic                         o_strobe,
    output ptum_pkg::t_res               o_res
);
    import ptum_pkg::*;

`include "packed_upper_triangular_matmul_assert.svh"

    localparam int U_DEPTH = N_MAX * (N_MAX + 1) / 2;
    localparam int UAW     = $clog2(U_DEPTH);
    localparam int F_DEPTH = N_MAX * M_COLS;
    localparam int FAW     = $clog2(F_DEPTH);

    logic signed [VAL_W-1:0] u_mem [U_DEPTH];
    logic signed [VAL_W-1:0] f_mem [F_DEPTH];

    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_size;
    logic [SIZE_W-1:0]   r_n;
    logic [ROW_W-1:0]    r_col;
    logic [SIZE_W-1:0]   r_lk;
    logic [ROW_W-1:0]    r_i;
    logic [ROW_W-1:0]    r_k;
    logic [UAW-1:0]      r_ua;
    logic [UAW-1:0]      r_ub;

    logic                r_ld_valid;
    logic                r_s1_valid;
    t_mac_tag            r_s1_tag;
    logic [SIZE_W-1:0]   r_s1_len;
    logic signed [VAL_W-1:0] r_udata;
    logic signed [VAL_W-1:0] r_fdata;

    logic                accept;
    logic                u_ok, f_ok, c_ok;
    logic [12:0]         u_rm1;
    logic [12:0]         u_la;
    logic [14:0]         f_la, f_ra, f_wa;
    logic [SIZE_W-1:0]   n_eff;
    logic                ld_issue, cp_issue;
    logic                lastk, lasti;
    logic [UAW-1:0]      next_base;

    t_chain_ctl              ctl;
    logic signed [VAL_W-1:0] ins_val;
    logic signed [VAL_W-1:0] cq [N_MAX];
    logic signed [VAL_W-1:0] head;

    logic                    m_valid;
    logic [ROW_W-1:0]        m_row;
    logic                    m_last;
    logic signed [VAL_W-1:0] m_value;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start & ~busy;

    assign u_ok = (i_req.cmd == CMD_LD_U) && (SIZE_W'(i_req.row) < SIZE_W'(N_MAX))
               && (SIZE_W'(i_req.col) < SIZE_W'(N_MAX)) && (i_req.col >= i_req.row);
    assign f_ok = (i_req.cmd == CMD_LD_F) && (SIZE_W'(i_req.row) < SIZE_W'(N_MAX))
               && (9'(i_req.col) < 9'(M_COLS));
    assign c_ok = (i_req.cmd == CMD_COMP) && (9'(i_req.col) < 9'(M_COLS));

    // packed row base: r*N - r(r-1)/2
    assign u_rm1 = 13'(i_req.row) - 13'd1;
    assign u_la  = 13'(i_req.row) * 13'(N_MAX) - ((13'(i_req.row) * u_rm1) >> 1)
                 + 13'(i_req.col) - 13'(i_req.row);
    assign f_la  = 15'(i_req.row) * 15'(M_COLS) + 15'(i_req.col);
    assign f_ra  = 15'(r_lk[ROW_W-1:0]) * 15'(M_COLS) + 15'(r_col);
    assign f_wa  = 15'(m_row) * 15'(M_COLS) + 15'(r_col);

    assign n_eff = (r_size == '0) ? SIZE_W'(1) :
                   (r_size > SIZE_W'(N_MAX)) ? SIZE_W'(N_MAX) : r_size;

    assign lastk     = ({1'b0, r_k} == r_n - SIZE_W'(1));
    assign lasti     = ({1'b0, r_i} == r_n - SIZE_W'(1));
    assign next_base = r_ub + UAW'(N_MAX) - UAW'(r_i);

    // memories
    always_ff @(posedge i_clk) begin
        if (accept && u_ok) begin
            u_mem[u_la[UAW-1:0]] <= i_req.value;
        end
        r_udata <= u_mem[r_ua];
    end

    always_ff @(posedge i_clk) begin
        if (accept && f_ok) begin
            f_mem[f_la[FAW-1:0]] <= i_req.value;
        end else if (m_valid) begin
            f_mem[f_wa[FAW-1:0]] <= m_value;
        end
        r_fdata <= f_mem[f_ra[FAW-1:0]];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        ld_issue = 1'b0;
        cp_issue = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && c_ok) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (r_lk == r_n) n_state = ST_COMP;
                else             ld_issue = 1'b1;
            end
            ST_COMP: begin
                cp_issue = 1'b1;
                if (lastk && lasti) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (m_valid && m_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= SIZE_W'(64);
            r_ld_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_n        <= SIZE_W'(1);
            r_lk       <= '0;
            r_i        <= '0;
            r_k        <= '0;
            r_ua       <= '0;
            r_ub       <= '0;
            r_col      <= '0;
        end else begin
            if (i_cfg_we) r_size <= i_cfg_wdata;
            r_ld_valid <= ld_issue;
            r_s1_valid <= cp_issue;
            if (accept && c_ok) begin
                r_n   <= n_eff;
                r_col <= i_req.col;
                r_lk  <= '0;
                r_i   <= '0;
                r_k   <= '0;
                r_ua  <= '0;
                r_ub  <= '0;
            end
            if (ld_issue) r_lk <= r_lk + SIZE_W'(1);
            if (cp_issue) begin
                if (lastk) begin
                    r_i  <= r_i + ROW_W'(1);
                    r_k  <= r_i + ROW_W'(1);
                    r_ub <= next_base;
                    r_ua <= next_base;
                end else begin
                    r_k  <= r_k + ROW_W'(1);
                    r_ua <= r_ua + UAW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tag.first   <= (r_k == r_i);
        r_s1_tag.lastk   <= lastk;
        r_s1_tag.row     <= r_i;
        r_s1_tag.lastrow <= lasti;
        r_s1_len         <= r_n - SIZE_W'(r_i);
    end

    // chain: loads shift in at n-1; the first product of a row drops the
    // head, the rest rotate the remaining span back into row order
    always_comb begin
        ctl     = '0;
        ins_val = head;
        if (r_ld_valid) begin
            ctl.shift  = 1'b1;
            ctl.ins_en = 1'b1;
            ctl.pos    = ROW_W'(r_n - SIZE_W'(1));
            ins_val    = r_fdata;
        end else if (r_s1_valid) begin
            ctl.shift  = 1'b1;
            ctl.ins_en = ~r_s1_tag.first;
            ctl.pos    = ROW_W'(r_s1_len - SIZE_W'(2));
        end
    end

    assign head = cq[0];

    for (genvar c = 0; c < N_MAX; c++) begin : g_cell
        ptum_cell #(.IDX(c)) u_cell (
            .i_clk (i_clk),
            .i_ctl (ctl),
            .i_nb  ((c == N_MAX - 1) ? '0 : cq[(c + 1) % N_MAX]),
            .i_ins (ins_val),
            .o_q   (cq[c])
        );
    end

    ptum_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_tag   (r_s1_tag),
        .i_a     (r_udata),
        .i_b     (head),
        .o_valid (m_valid),
        .o_row   (m_row),
        .o_last  (m_last),
        .o_value (m_value)
    );

    assign o_strobe          = m_valid;
    assign o_res.out_row     = m_row;
    assign o_res.out_col     = r_col;
    assign o_res.out_value   = m_value;
    assign o_res.last        = m_last;

    `PTUM_ASSERT_IMP(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy)
    `PTUM_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, r_ld_valid, !r_s1_valid)
    `PTUM_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_strobe && o_res.last, !busy)
    `PTUM_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, accept && c_ok, busy)

endmodule
